@@ rtl/owtm_pkg.sv @@
// Shared types, register map and helpers for the one-wire temperature master.
`default_nettype none
package owtm_pkg;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_RESET_LOW, REG_RESET_REL, REG_PRES_LOW, REG_PRES_HIGH,
    REG_SHORT, REG_LONG, REG_RD_SAMPLE, REG_RD_REC
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_NONE = 3'd0, MODE_RESET = 3'd1, MODE_WRITE = 3'd2, MODE_READ = 3'd3,
    MODE_MEASURE = 3'd4
  } mode_t;

  typedef enum logic [1:0] { OP_RESET, OP_WRITE, OP_READ } op_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] reset_release_ticks;
    logic [7:0] presence_low_timeout;
    logic [7:0] presence_high_timeout;
    logic [5:0] short_pulse_ticks;
    logic [7:0] long_slot_ticks;
    logic [5:0] read_sample_ticks;
    logic [7:0] read_recovery_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{10'd750, 8'd15, 8'd200, 8'd240, 6'd2, 8'd60, 6'd12, 8'd50};

  function automatic op_t measure_kind(input logic [2:0] step);
    case (step)
      3'd0, 3'd3: measure_kind = OP_RESET;
      3'd6, 3'd7: measure_kind = OP_READ;
      default:    measure_kind = OP_WRITE;
    endcase
  endfunction

  function automatic logic [7:0] measure_byte(input logic [2:0] step);
    case (step)
      3'd1, 3'd4: measure_byte = 8'hCC;
      3'd2:       measure_byte = 8'h44;
      3'd5:       measure_byte = 8'hBE;
      default:    measure_byte = 8'h00;
    endcase
  endfunction

  // |raw| saturated at 2047, times 5/8 truncated, sign restored
  function automatic logic [11:0] to_tenths(input logic [15:0] raw);
    logic        neg;
    logic [15:0] mag;
    logic [10:0] sat;
    logic [13:0] prod;
    logic [11:0] t;
    neg  = raw[15];
    mag  = neg ? (16'd0 - raw) : raw;
    sat  = (mag > 16'd2047) ? 11'd2047 : mag[10:0];
    prod = {3'd0, sat} + {1'b0, sat, 2'b00};
    t    = {1'b0, prod[13:3]};
    to_tenths = neg ? (12'd0 - t) : t;
  endfunction
endpackage
`default_nettype wire

@@ rtl/owtm_regs.sv @@
// APB register file for the slot timing settings.
`default_nettype none
module owtm_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [owtm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [owtm_pkg::DATA_W-1:0] pwdata,
  output logic      [owtm_pkg::DATA_W-1:0] prdata,
  output owtm_pkg::cfg_t                   cfg
);
  import owtm_pkg::*;
  logic     wr;
  reg_idx_t idx;
  assign wr  = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      case (idx)
        REG_RESET_LOW: cfg.reset_low_ticks       <= pwdata[9:0];
        REG_RESET_REL: cfg.reset_release_ticks   <= pwdata[7:0];
        REG_PRES_LOW:  cfg.presence_low_timeout  <= pwdata[7:0];
        REG_PRES_HIGH: cfg.presence_high_timeout <= pwdata[7:0];
        REG_SHORT:     cfg.short_pulse_ticks     <= pwdata[5:0];
        REG_LONG:      cfg.long_slot_ticks       <= pwdata[7:0];
        REG_RD_SAMPLE: cfg.read_sample_ticks     <= pwdata[5:0];
        REG_RD_REC:    cfg.read_recovery_ticks   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_RESET_LOW: prdata = {22'd0, cfg.reset_low_ticks};
      REG_RESET_REL: prdata = {24'd0, cfg.reset_release_ticks};
      REG_PRES_LOW:  prdata = {24'd0, cfg.presence_low_timeout};
      REG_PRES_HIGH: prdata = {24'd0, cfg.presence_high_timeout};
      REG_SHORT:     prdata = {26'd0, cfg.short_pulse_ticks};
      REG_LONG:      prdata = {24'd0, cfg.long_slot_ticks};
      REG_RD_SAMPLE: prdata = {26'd0, cfg.read_sample_ticks};
      REG_RD_REC:    prdata = {24'd0, cfg.read_recovery_ticks};
      default:       prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/owtm_core.sv @@
// Bus sequencer: one tick per beat, one result beat per tick.
`default_nettype none
module owtm_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire owtm_pkg::cfg_t cfg,
  input  wire logic           step,
  input  wire logic [2:0]     mode,
  input  wire logic           line_in,
  input  wire logic [7:0]     write_data,
  output logic                drive_low,
  output logic                busy_res,
  output logic                done_res,
  output logic                presence_error,
  output logic [7:0]          read_data,
  output logic signed [11:0]  temperature_tenths
);
  import owtm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_REL, PH_CHK_LOW, PH_CHK_HIGH,
    PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [9:0]  tick_count, tick_next, tc, tinc;
  logic [2:0]  bit_index, bit_next;
  logic [7:0]  shift_byte, shift_next;
  logic [2:0]  sequence_step, step_next;
  logic [2:0]  active_command, cmd_next;
  logic [7:0]  low_byte_hold, low_next;
  logic        presence_flag, pres_next;
  logic [7:0]  read_byte_reg, rd_next;
  logic [11:0] temperature_reg, temp_next;
  logic        drive, done, end_op, tdone, b;
  logic [9:0]  dur;
  op_t         k;
  logic [7:0]  kb;

  always_comb begin
    phase_next = phase; tick_next = tick_count; bit_next = bit_index;
    shift_next = shift_byte; step_next = sequence_step; cmd_next = active_command;
    low_next = low_byte_hold; pres_next = presence_flag; rd_next = read_byte_reg;
    temp_next = temperature_reg; drive = 1'b0; done = 1'b0; end_op = 1'b0;
    ph = phase; tc = tick_count; k = OP_RESET; kb = 8'd0;
    // launch a command from idle
    if (phase == PH_IDLE && mode >= MODE_RESET && mode <= MODE_MEASURE) begin
      cmd_next = mode; step_next = 3'd0; tc = '0; bit_next = 3'd0;
      case (mode)
        MODE_RESET: ph = PH_RST_LOW;
        MODE_WRITE: begin ph = PH_WR_LOW; shift_next = write_data; end
        MODE_READ:  begin ph = PH_RD_LOW; shift_next = 8'd0; end
        default:    ph = PH_RST_LOW;
      endcase
    end
    b = shift_next[0];
    case (ph)
      PH_RST_LOW:  dur = cfg.reset_low_ticks;
      PH_RST_REL:  dur = {2'd0, cfg.reset_release_ticks};
      PH_WR_LOW:   dur = b ? {4'd0, cfg.short_pulse_ticks} : {2'd0, cfg.long_slot_ticks};
      PH_WR_HIGH:  dur = b ? {2'd0, cfg.long_slot_ticks} : {4'd0, cfg.short_pulse_ticks};
      PH_RD_LOW:   dur = {4'd0, cfg.short_pulse_ticks};
      PH_RD_WAIT:  dur = {4'd0, cfg.read_sample_ticks};
      default:     dur = {2'd0, cfg.read_recovery_ticks};
    endcase
    tinc  = tc + 10'd1;
    tdone = tinc >= dur;
    tick_next = tdone ? 10'd0 : tinc;
    phase_next = ph;
    case (ph)
      PH_RST_LOW: begin drive = 1'b1; if (tdone) phase_next = PH_RST_REL; end
      PH_RST_REL: if (tdone) phase_next = PH_CHK_LOW;
      PH_CHK_LOW: begin
        tick_next = tinc;
        if (tc >= {2'd0, cfg.presence_low_timeout}) begin
          pres_next = 1'b1; end_op = 1'b1; tick_next = tc;
        end else if (!line_in) begin
          tick_next = '0; phase_next = PH_CHK_HIGH;
        end
      end
      PH_CHK_HIGH: begin
        tick_next = tinc;
        if (tc >= {2'd0, cfg.presence_high_timeout}) begin
          pres_next = 1'b1; end_op = 1'b1; tick_next = tc;
        end else if (line_in) begin
          pres_next = 1'b0; end_op = 1'b1; tick_next = tc;
        end
      end
      PH_WR_LOW: begin drive = 1'b1; if (tdone) phase_next = PH_WR_HIGH; end
      PH_WR_HIGH: if (tdone) begin
        shift_next = {1'b0, shift_next[7:1]};
        if (bit_next == 3'd7) end_op = 1'b1;
        else begin bit_next = bit_next + 3'd1; phase_next = PH_WR_LOW; end
      end
      PH_RD_LOW: begin drive = 1'b1; if (tdone) phase_next = PH_RD_WAIT; end
      PH_RD_WAIT: if (tdone) begin
        shift_next = {line_in, shift_next[7:1]}; phase_next = PH_RD_REC;
      end
      PH_RD_REC: if (tdone) begin
        if (bit_next == 3'd7) end_op = 1'b1;
        else begin bit_next = bit_next + 3'd1; phase_next = PH_RD_LOW; end
      end
      default: begin phase_next = PH_IDLE; tick_next = tc; end
    endcase
    if (end_op) begin
      if (ph == PH_RD_REC) begin
        rd_next = shift_next;
        if (cmd_next == MODE_MEASURE) begin
          if (step_next == 3'd6) low_next = shift_next;
          else if (step_next == 3'd7) temp_next = to_tenths({shift_next, low_byte_hold});
        end
      end
      if (cmd_next == MODE_MEASURE && step_next != 3'd7) begin
        step_next = step_next + 3'd1;
        k = measure_kind(step_next); kb = measure_byte(step_next);
        tick_next = '0; bit_next = 3'd0;
        case (k)
          OP_RESET: phase_next = PH_RST_LOW;
          OP_WRITE: begin shift_next = kb; phase_next = PH_WR_LOW; end
          default:  begin shift_next = 8'd0; phase_next = PH_RD_LOW; end
        endcase
      end else begin
        phase_next = PH_IDLE; tick_next = '0; step_next = 3'd0; done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; tick_count <= '0; bit_index <= '0; shift_byte <= '0;
      sequence_step <= '0; active_command <= '0; low_byte_hold <= '0;
      presence_flag <= 1'b0; read_byte_reg <= '0; temperature_reg <= '0;
      drive_low <= 1'b0; busy_res <= 1'b0; done_res <= 1'b0; presence_error <= 1'b0;
      read_data <= '0; temperature_tenths <= '0;
    end else if (step) begin
      phase <= phase_next; tick_count <= tick_next; bit_index <= bit_next;
      shift_byte <= shift_next; sequence_step <= step_next; active_command <= cmd_next;
      low_byte_hold <= low_next; presence_flag <= pres_next; read_byte_reg <= rd_next;
      temperature_reg <= temp_next;
      drive_low <= drive; busy_res <= (phase_next != PH_IDLE); done_res <= done;
      presence_error <= pres_next; read_data <= rd_next;
      temperature_tenths <= temp_next;
    end
  end
endmodule
`default_nettype wire

@@ rtl/onewire_temp_sensor_master_top.sv @@
// Top level of the one-wire temperature sensor bus master.
// The result beat is registered and appears in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle; the result register frees as the
// next beat enters, so in_ready follows out_ready or an empty output slot.
// Reset (rst, synchronous): phase idle, counters and result registers cleared,
// timing registers back to their default values.
`default_nettype none
module onewire_temp_sensor_master_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic        line_in,
  input  wire logic [7:0]  write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             drive_low,
  output logic             busy_res,
  output logic             done_res,
  output logic             presence_error,
  output logic [7:0]       read_data,
  output logic signed [11:0] temperature_tenths,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [owtm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [owtm_pkg::DATA_W-1:0] pwdata,
  output logic [owtm_pkg::DATA_W-1:0]      prdata,
  output logic             pready
);
  import owtm_pkg::*;
  cfg_t cfg;
  logic step;

  assign pready   = 1'b1;
  // take a new beat whenever the held result leaves or none is held
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  owtm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  owtm_core u_core (
    .clk, .rst, .cfg, .step, .mode, .line_in, .write_data,
    .drive_low, .busy_res, .done_res, .presence_error, .read_data, .temperature_tenths
  );
endmodule
`default_nettype wire

@@ rtl/owtm_checker.sv @@
// Port-level checker for the one-wire master, bound to the top level.
`default_nettype none
module owtm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic busy_res,
  input wire logic done_res,
  input wire logic pready
);
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res) else $error("done with busy");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("ready low with empty output");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid) else $error("result beat missing");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind onewire_temp_sensor_master_top owtm_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .busy_res, .done_res, .pready
);
`default_nettype wire

@@ verif/owtm_checker.sv @@
// Bus-master predictor and result scoreboard for the one-wire temperature master.
`timescale 1ns / 1ps
module owtm_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic        line_in,
  input  wire logic [7:0]  write_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        drive_low,
  input  wire logic        busy_res,
  input  wire logic        done_res,
  input  wire logic        presence_error,
  input  wire logic [7:0]  read_data,
  input  wire logic [11:0] temperature_tenths,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [owtm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [owtm_pkg::DATA_W-1:0] pwdata,
  output int               fail_count,
  output int               pending,
  output logic             bus_idle
);
  import owtm_pkg::*;

  typedef enum logic [3:0] {
    BS_IDLE, BS_RST_LOW, BS_RST_REL, BS_CHK_LOW, BS_CHK_HIGH,
    BS_WR_LOW, BS_WR_HIGH, BS_RD_LOW, BS_RD_WAIT, BS_RD_REC
  } bus_state_t;

  typedef struct packed {
    logic        drive;
    logic        busy;
    logic        done;
    logic        pres_err;
    logic [7:0]  rd_byte;
    logic [11:0] tenths;
  } tick_res_t;

  localparam logic [7:0] SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CONVERT_T = 8'h44;
  localparam logic [7:0] READ_PAD  = 8'hBE;
  localparam int unsigned SEQ_LEN  = 8;

  cfg_t        cfg;
  bus_state_t  bstate;
  logic [9:0]  tcnt;
  logic [2:0]  bit_no;
  logic [7:0]  shreg;
  logic [3:0]  seq_pos;
  logic [2:0]  cur_cmd;
  logic [7:0]  temp_lo;
  logic        pres_flag;
  logic [7:0]  last_byte;
  logic [11:0] last_tenths;

  tick_res_t   tick_results_q[$];
  tick_res_t   want, seen;

  function automatic op_t seq_op(input logic [3:0] s);
    case (s)
      4'd0, 4'd3: return OP_RESET;
      4'd6, 4'd7: return OP_READ;
      default:    return OP_WRITE;
    endcase
  endfunction

  function automatic logic [7:0] seq_byte(input logic [3:0] s);
    case (s)
      4'd1, 4'd4: return SKIP_ROM;
      4'd2:       return CONVERT_T;
      4'd5:       return READ_PAD;
      default:    return 8'h00;
    endcase
  endfunction

  task automatic clear_bus();
    cfg = CFG_RESET;
    bstate = BS_IDLE;
    tcnt = '0; bit_no = '0; shreg = '0; seq_pos = '0; cur_cmd = '0;
    temp_lo = '0; pres_flag = 1'b0; last_byte = '0; last_tenths = '0;
  endtask

  function automatic void launch(input op_t kind, input logic [7:0] b);
    tcnt = '0;
    bit_no = '0;
    case (kind)
      OP_RESET: bstate = BS_RST_LOW;
      OP_WRITE: begin
        shreg = b;
        bstate = BS_WR_LOW;
      end
      default: begin
        shreg = '0;
        bstate = BS_RD_LOW;
      end
    endcase
  endfunction

  // spend one tick of a timed phase; a zero duration still costs one tick
  function automatic bit slot_over(input int unsigned dur);
    tcnt = tcnt + 10'd1;
    if (tcnt >= dur) begin
      tcnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [11:0] raw_to_tenths(input logic [15:0] raw);
    logic [15:0] mag;
    int unsigned t;
    mag = raw[15] ? 16'(16'd0 - raw) : raw;
    if (mag > 16'd2047) mag = 16'd2047;
    t = (int'(mag) * 5) / 8;
    return raw[15] ? 12'(12'd0 - 12'(t)) : 12'(t);
  endfunction

  function automatic bit end_of_op();
    if (bstate == BS_RD_REC) begin
      last_byte = shreg;
      if (cur_cmd == MODE_MEASURE) begin
        if (seq_pos == 4'd6) temp_lo = last_byte;
        else if (seq_pos == 4'd7) last_tenths = raw_to_tenths({last_byte, temp_lo});
      end
    end
    if (cur_cmd == MODE_MEASURE && seq_pos + 1 < SEQ_LEN) begin
      seq_pos = seq_pos + 4'd1;
      launch(seq_op(seq_pos), seq_byte(seq_pos));
      return 1'b0;
    end
    bstate = BS_IDLE;
    tcnt = '0;
    seq_pos = '0;
    return 1'b1;
  endfunction

  task automatic advance_bus(input logic [2:0] m, input logic ln, input logic [7:0] wd,
                             output tick_res_t r);
    logic drv, fin, fin_cmd, b;
    drv = 1'b0; fin = 1'b0; fin_cmd = 1'b0;
    if (bstate == BS_IDLE && m >= MODE_RESET && m <= MODE_MEASURE) begin
      cur_cmd = m;
      seq_pos = '0;
      case (m)
        MODE_RESET: launch(OP_RESET, 8'h00);
        MODE_WRITE: launch(OP_WRITE, wd);
        MODE_READ:  launch(OP_READ, 8'h00);
        default:    launch(seq_op(4'd0), seq_byte(4'd0));
      endcase
    end
    b = shreg[0];
    case (bstate)
      BS_RST_LOW: begin
        drv = 1'b1;
        if (slot_over(cfg.reset_low_ticks)) bstate = BS_RST_REL;
      end
      BS_RST_REL: if (slot_over(cfg.reset_release_ticks)) bstate = BS_CHK_LOW;
      BS_CHK_LOW: begin
        if (tcnt >= cfg.presence_low_timeout) begin
          pres_flag = 1'b1;
          fin = 1'b1;
        end else if (!ln) begin
          tcnt = '0;
          bstate = BS_CHK_HIGH;
        end else tcnt = tcnt + 10'd1;
      end
      BS_CHK_HIGH: begin
        if (tcnt >= cfg.presence_high_timeout) begin
          pres_flag = 1'b1;
          fin = 1'b1;
        end else if (ln) begin
          pres_flag = 1'b0;
          fin = 1'b1;
        end else tcnt = tcnt + 10'd1;
      end
      BS_WR_LOW: begin
        drv = 1'b1;
        if (slot_over(b ? cfg.short_pulse_ticks : cfg.long_slot_ticks)) bstate = BS_WR_HIGH;
      end
      BS_WR_HIGH: begin
        if (slot_over(b ? cfg.long_slot_ticks : cfg.short_pulse_ticks)) begin
          shreg = shreg >> 1;
          if (bit_no == 3'd7) fin = 1'b1;
          else begin
            bit_no = bit_no + 3'd1;
            bstate = BS_WR_LOW;
          end
        end
      end
      BS_RD_LOW: begin
        drv = 1'b1;
        if (slot_over(cfg.short_pulse_ticks)) bstate = BS_RD_WAIT;
      end
      BS_RD_WAIT: begin
        if (slot_over(cfg.read_sample_ticks)) begin
          shreg = {ln, shreg[7:1]};
          bstate = BS_RD_REC;
        end
      end
      BS_RD_REC: begin
        if (slot_over(cfg.read_recovery_ticks)) begin
          if (bit_no == 3'd7) fin = 1'b1;
          else begin
            bit_no = bit_no + 3'd1;
            bstate = BS_RD_LOW;
          end
        end
      end
      default: bstate = BS_IDLE;
    endcase
    if (fin) fin_cmd = end_of_op();
    r = '{drv, bstate != BS_IDLE, fin_cmd, pres_flag, last_byte, last_tenths};
  endtask

  task automatic store_reg(input logic [2:0] idx, input logic [DATA_W-1:0] v);
    case (reg_idx_t'(idx))
      REG_RESET_LOW: cfg.reset_low_ticks       = v[9:0];
      REG_RESET_REL: cfg.reset_release_ticks   = v[7:0];
      REG_PRES_LOW:  cfg.presence_low_timeout  = v[7:0];
      REG_PRES_HIGH: cfg.presence_high_timeout = v[7:0];
      REG_SHORT:     cfg.short_pulse_ticks     = v[5:0];
      REG_LONG:      cfg.long_slot_ticks       = v[7:0];
      REG_RD_SAMPLE: cfg.read_sample_ticks     = v[5:0];
      default:       cfg.read_recovery_ticks   = v[7:0];
    endcase
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    bus_idle = 1'b1;
    clear_bus();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_bus();
      tick_results_q.delete();
    end else begin
      // compare the result beat first, then predict the tick beat taken here
      if (out_valid && out_ready) begin
        seen = '{drive_low, busy_res, done_res, presence_error, read_data, temperature_tenths};
        if (tick_results_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("result beat with nothing pending at %0t", $time);
        end else begin
          want = tick_results_q.pop_front();
          if (seen != want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch at %0t: drive %b/%b busy %b/%b done %b/%b pres %b/%b",
                        " rd %h/%h temp %h/%h (exp/got)"},
                       $time, want.drive, seen.drive, want.busy, seen.busy, want.done, seen.done,
                       want.pres_err, seen.pres_err, want.rd_byte, seen.rd_byte,
                       want.tenths, seen.tenths);
          end
        end
      end
      if (psel && penable && pwrite && pready) store_reg(paddr[4:2], pwdata);
      if (in_valid && in_ready) begin
        advance_bus(mode, line_in, write_data, want);
        tick_results_q.push_back(want);
      end
    end
    pending  <= tick_results_q.size();
    bus_idle <= (bstate == BS_IDLE);
  end

endmodule

@@ verif/tb_top.sv @@
// Stimulus, register setup and verdict for the one-wire temperature master.
`timescale 1ns / 1ps
module tb_top;
  import owtm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 650;
  localparam longint     CYCLE_LIMIT  = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [2:0]  mode = MODE_NONE;
  logic        line_in = 1'b1;
  logic [7:0]  write_data = 8'h00;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;

  wire logic        in_ready, out_valid, pready;
  wire logic        drive_low, busy_res, done_res, presence_error;
  wire logic [7:0]  read_data;
  wire logic signed [11:0] temperature_tenths;
  wire logic [DATA_W-1:0]  prdata;

  int     fail_count, pending;
  logic   bus_idle;
  int     ticks_sent = 0;
  bit     steady_in = 1'b0;   // no gaps on the tick side while set
  bit     steady_out = 1'b0;  // no stalls on the result side while set
  longint cycles = 0;

  onewire_temp_sensor_master_top dut (.*);

  owtm_scoreboard u_scoreboard (
    .clk, .rst, .in_valid, .in_ready, .mode, .line_in, .write_data,
    .out_valid, .out_ready, .drive_low, .busy_res, .done_res, .presence_error,
    .read_data, .temperature_tenths, .psel, .penable, .pwrite, .pready, .paddr,
    .pwdata, .fail_count, .pending, .bus_idle
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** onewire_temp_sensor_master_top: FAILED **");
      $finish;
    end
  end

  // result side: draw a stall per beat, then hold ready until the beat goes
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // one tick beat; valid stays up across back-to-back beats
  task automatic send_tick(input logic [2:0] m, input logic ln, input logic [7:0] wd);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    line_in    <= ln;
    write_data <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // tick with a random line level until the predicted bus is idle and all results are in
  task automatic drain_bus();
    do send_tick(MODE_NONE, 1'($urandom_range(0, 1)), 8'($urandom));
    while (!bus_idle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timing(input int unsigned rl, rr, pl, ph, sp, ls, rs, rc);
    apb_write(REG_RESET_LOW, rl);
    apb_write(REG_RESET_REL, rr);
    apb_write(REG_PRES_LOW, pl);
    apb_write(REG_PRES_HIGH, ph);
    apb_write(REG_SHORT, sp);
    apb_write(REG_LONG, ls);
    apb_write(REG_RD_SAMPLE, rs);
    apb_write(REG_RD_REC, rc);
    @(posedge clk);
  endtask

  // mostly plain ticks; commands when idle, with noise and commands while busy
  task automatic random_tick();
    logic [2:0] m;
    int pick;
    m = MODE_NONE;
    pick = $urandom_range(0, 99);
    if (bus_idle && pick < 30) begin
      case ($urandom_range(0, 4))
        0:       m = MODE_RESET;
        1:       m = MODE_WRITE;
        2:       m = MODE_READ;
        default: m = MODE_MEASURE;
      endcase
    end else if (pick >= 88) begin
      m = 3'($urandom_range(1, 7));
    end
    send_tick(m, 1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  initial begin
    int phase_end;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all timings zero, so every phase lasts one tick and checks fail at once
    steady_in = 1'b1;
    set_timing(0, 0, 0, 0, 0, 0, 0, 0);
    send_tick(MODE_RESET, 1'b0, 8'h00);
    drain_bus();
    send_tick(MODE_WRITE, 1'b1, 8'hFF);
    send_tick(MODE_READ, 1'b0, 8'h00);   // ignored while the write runs
    drain_bus();
    send_tick(MODE_WRITE, 1'b0, 8'h00);
    drain_bus();
    send_tick(3'd5, 1'b1, 8'hA5);
    send_tick(3'd6, 1'b0, 8'h5A);
    send_tick(3'd7, 1'b1, 8'h00);
    send_tick(MODE_READ, 1'b1, 8'h00);
    drain_bus();
    send_tick(MODE_MEASURE, 1'b0, 8'h00);
    drain_bus();

    // longer timings: one of each single command
    steady_in = 1'b0;
    steady_out = 1'b1;
    set_timing(40, 9, 12, 12, 3, 5, 4, 6);
    send_tick(MODE_RESET, 1'b1, 8'h00);
    drain_bus();
    send_tick(MODE_WRITE, 1'b0, 8'($urandom));
    drain_bus();
    send_tick(MODE_READ, 1'b1, 8'h00);
    drain_bus();

    // random phases, mostly short timings so measurements finish quickly
    while (ticks_sent < RANDOM_ITEMS) begin
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      set_timing($urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 6),
                 $urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 4),
                 $urandom_range(0, 3), $urandom_range(0, 3));
      phase_end = ticks_sent + $urandom_range(80, 160);
      while (ticks_sent < phase_end) random_tick();
      drain_bus();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("** onewire_temp_sensor_master_top: PASSED **");
    else $display("** onewire_temp_sensor_master_top: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/owtm_pkg.sv
rtl/owtm_regs.sv
rtl/owtm_core.sv
rtl/onewire_temp_sensor_master_top.sv
rtl/owtm_checker.sv
verif/owtm_checker.sv
verif/tb_top.sv
